// ===== sv/ip6tb_pkg.sv =====
package ip6tb_pkg;

  localparam int unsigned GroupCount = 8;
  localparam int unsigned GroupWidth = 16;
  localparam int unsigned IdxWidth   = $clog2(GroupCount);

  localparam logic [7:0] CharNul   = 8'h00;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharLowA  = 8'h61;
  localparam logic [7:0] CharLowF  = 8'h66;
  localparam logic [7:0] CharUpA   = 8'h41;
  localparam logic [7:0] CharUpF   = 8'h46;
  localparam logic [3:0] HexTen    = 4'd10;

  typedef logic [GroupWidth-1:0] group_t;
  typedef logic [IdxWidth-1:0]   group_idx_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       end_of_text;
  } in_word_t;

  typedef struct packed {
    group_t group_0;
    group_t group_1;
    group_t group_2;
    group_t group_3;
    group_t group_4;
    group_t group_5;
    group_t group_6;
    group_t group_7;
    logic   group_overflow;
  } out_word_t;

  typedef struct packed {
    logic       hit;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(logic [7:0] ch);
    hex_t r;
    logic [7:0] d;
    r = '{hit: 1'b0, value: 4'd0};
    d = 8'd0;
    if (ch >= CharZero && ch <= CharNine) begin
      d = ch - CharZero;
      r = '{hit: 1'b1, value: d[3:0]};
    end else if (ch >= CharLowA && ch <= CharLowF) begin
      d = ch - CharLowA;
      r = '{hit: 1'b1, value: d[3:0] + HexTen};
    end else if (ch >= CharUpA && ch <= CharUpF) begin
      d = ch - CharUpA;
      r = '{hit: 1'b1, value: d[3:0] + HexTen};
    end
    return r;
  endfunction

endpackage

// ===== sv/ip6tb_intf.sv =====
interface ip6tb_in_if;
  logic                valid;
  logic                ready;
  ip6tb_pkg::in_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface ip6tb_out_if;
  logic                 valid;
  logic                 ready;
  ip6tb_pkg::out_word_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/ipv6_text_to_binary.sv =====
// IPv6 text-to-binary parser. Takes one address character per word on in_i
// (text_char, end_of_text) and returns one word on out_o with the eight 16-bit
// groups after '::' expansion, plus group_overflow when the text had more than
// eight groups (later digits are dropped and no expansion is done then). NUL is
// ignored but still honors end_of_text. One character is taken every cycle when
// in_i.ready is high; the word carrying end_of_text loads the result register,
// so out_o.valid rises in the cycle after it is accepted. The result register
// holds until taken; while it is full and unread, in_i.ready is low. After a
// result the parser is back in its reset state and the next character starts
// a new address.
module ipv6_text_to_binary (
  input  logic         clk_i,
  input  logic         rst_ni,
  ip6tb_in_if.sink     in_i,
  ip6tb_out_if.source  out_o
);
  import ip6tb_pkg::*;

  // parse state
  group_t     groups_q [GroupCount];
  group_t     groups_d [GroupCount];
  group_idx_t cur_q, cur_d;
  group_idx_t gap_q, gap_d;
  logic       gap_seen_q, gap_seen_d;
  logic       prev_colon_q, prev_colon_d;
  logic       first_q, first_d;
  logic       ovf_q, ovf_d;

  // result register
  logic       out_valid_q, out_valid_d;
  out_word_t  out_data_q, out_data_d;

  logic       in_fire;
  hex_t       hex;
  group_t     res [GroupCount];

  // a new word goes in whenever the result slot is free or being drained
  assign in_i.ready  = !out_valid_q || out_o.ready;
  assign in_fire     = in_i.valid && in_i.ready;
  assign hex         = hex_decode(in_i.data.text_char);

  // character update, before any end-of-text handling
  always_comb begin
    groups_d     = groups_q;
    cur_d        = cur_q;
    gap_d        = gap_q;
    gap_seen_d   = gap_seen_q;
    prev_colon_d = prev_colon_q;
    first_d      = first_q;
    ovf_d        = ovf_q;
    if (in_fire && in_i.data.text_char != CharNul) begin
      if (in_i.data.text_char == CharColon) begin
        if (!first_q && prev_colon_q) begin
          // '::' - last one wins, ignored once overflowed
          if (!ovf_q) begin
            gap_d      = cur_q;
            gap_seen_d = 1'b1;
          end
        end else if (!first_q) begin
          if (cur_q == group_idx_t'(GroupCount - 1)) begin
            ovf_d = 1'b1;
          end else begin
            cur_d = cur_q + group_idx_t'(1);
          end
        end
        prev_colon_d = 1'b1;
      end else begin
        if (hex.hit && !ovf_q) begin
          groups_d[cur_q] = {groups_q[cur_q][GroupWidth-5:0], hex.value};
        end
        prev_colon_d = 1'b0;
      end
      first_d = 1'b0;
    end
  end

  // '::' expansion on the updated groups: slide the tail up by fill places
  always_comb begin
    logic [IdxWidth:0] gap_c;
    logic [IdxWidth:0] fill;
    logic [IdxWidth:0] idx;
    gap_c = (gap_d > cur_d) ? {1'b0, cur_d} : {1'b0, gap_d};
    fill  = (IdxWidth+1)'(GroupCount - 1) - {1'b0, cur_d};
    for (int i = 0; i < GroupCount; i++) begin
      idx = (IdxWidth+1)'(i) - fill;
      if (!gap_seen_d || ovf_d) begin
        res[i] = groups_d[i];
      end else if ((IdxWidth+1)'(i) < gap_c) begin
        res[i] = groups_d[i];
      end else if ((IdxWidth+1)'(i) < gap_c + fill) begin
        res[i] = '0;
      end else begin
        res[i] = groups_d[idx[IdxWidth-1:0]];
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    if (in_fire && in_i.data.end_of_text) begin
      out_valid_d = 1'b1;
      out_data_d  = '{group_0: res[0], group_1: res[1], group_2: res[2],
                      group_3: res[3], group_4: res[4], group_5: res[5],
                      group_6: res[6], group_7: res[7], group_overflow: ovf_d};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < GroupCount; i++) begin
        groups_q[i] <= '0;
      end
      cur_q        <= '0;
      gap_q        <= '0;
      gap_seen_q   <= 1'b0;
      prev_colon_q <= 1'b0;
      first_q      <= 1'b1;
      ovf_q        <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (in_fire && in_i.data.end_of_text) begin
        // address done: back to the reset state
        for (int i = 0; i < GroupCount; i++) begin
          groups_q[i] <= '0;
        end
        cur_q        <= '0;
        gap_q        <= '0;
        gap_seen_q   <= 1'b0;
        prev_colon_q <= 1'b0;
        first_q      <= 1'b1;
        ovf_q        <= 1'b0;
      end else begin
        groups_q     <= groups_d;
        cur_q        <= cur_d;
        gap_q        <= gap_d;
        gap_seen_q   <= gap_seen_d;
        prev_colon_q <= prev_colon_d;
        first_q      <= first_d;
        ovf_q        <= ovf_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

endmodule

// ===== sv/ip6tb_checker.sv =====
module ip6tb_checker (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 in_valid_i,
  input logic                 in_ready_i,
  input ip6tb_pkg::in_word_t  in_data_i,
  input logic                 out_valid_i,
  input logic                 out_ready_i,
  input ip6tb_pkg::out_word_t out_data_i
);
  import ip6tb_pkg::*;

  logic in_fire;
  assign in_fire = in_valid_i && in_ready_i;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && in_data_i.end_of_text |=> out_valid_i)
    else $error("no result after last character");

  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(in_fire && in_data_i.end_of_text))
    else $error("result without a last character");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i |-> in_ready_i)
    else $error("input stalled with empty result slot");

endmodule

bind ipv6_text_to_binary ip6tb_checker u_ip6tb_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_data_i   (in_i.data),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_data_i  (out_o.data)
);
